// ===== design/gol_pkg.sv =====
// Shared types, codes and constants for the Gaussian overlap accumulator.
package gol_pkg;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_TEST  = 3'd1;
  localparam logic [2:0] OP_ACC   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [3:0] SEL_MEAN_X = 4'd0;
  localparam logic [3:0] SEL_MEAN_Y = 4'd1;
  localparam logic [3:0] SEL_MEAN_Z = 4'd2;
  localparam logic [3:0] SEL_PREF   = 4'd3;
  localparam logic [3:0] SEL_COV_XX = 4'd4;
  localparam logic [3:0] SEL_THRESH = 4'd10;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         component;
    logic [1:0]         atom_type;
    logic [3:0]         table_select;
    logic signed [31:0] load_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } req_t;

  typedef struct packed {
    logic [47:0]        pair_overlap;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    logic signed [47:0] grad_z;
    logic               in_list;
    logic [47:0]        component_sum;
  } res_t;

  function automatic logic [2:0] cov_index(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] rc;
    rc = {row, col};
    case (rc)
      4'b0000: cov_index = 3'd0;
      4'b0001, 4'b0100: cov_index = 3'd1;
      4'b0010, 4'b1000: cov_index = 3'd2;
      4'b0101: cov_index = 3'd3;
      4'b0110, 4'b1001: cov_index = 3'd4;
      4'b1010: cov_index = 3'd5;
      default: cov_index = 3'd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) sat32 = 32'sh7FFF_FFFF;
    else if (v < -50'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
    if (v > 58'sh0_7FFF_FFFF_FFFF) sat48 = 48'sh7FFF_FFFF_FFFF;
    else if (v < -58'sh0_8000_0000_0000) sat48 = 48'sh8000_0000_0000;
    else sat48 = v[47:0];
  endfunction

endpackage

// ===== design/gol_ram.sv =====
// Generic single-port-write, registered-read RAM.
module gol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gol_exp_lut.sv =====
// Constant table of 2^(-i/SEGS) in Q1.40 with two adjacent taps.
module gol_exp_lut import gol_pkg::*; #(
  parameter int SEGS = 64,
  localparam int SW = $clog2(SEGS + 1)
) (
  input  logic [SW-1:0] seg,
  output logic [40:0]   lo_tap,
  output logic [40:0]   hi_tap
);

  logic [40:0] tab [SEGS+1];

  for (genvar i = 0; i <= SEGS; i++) begin : g_tab
    localparam logic [63:0] U   = (64'(i) * LN2_Q30) / SEGS;
    localparam logic [63:0] T1  = (((64'd1 << 30) * U) >> 30) / 1;
    localparam logic [63:0] T2  = ((T1 * U) >> 30) / 2;
    localparam logic [63:0] T3  = ((T2 * U) >> 30) / 3;
    localparam logic [63:0] T4  = ((T3 * U) >> 30) / 4;
    localparam logic [63:0] T5  = ((T4 * U) >> 30) / 5;
    localparam logic [63:0] T6  = ((T5 * U) >> 30) / 6;
    localparam logic [63:0] T7  = ((T6 * U) >> 30) / 7;
    localparam logic [63:0] T8  = ((T7 * U) >> 30) / 8;
    localparam logic [63:0] T9  = ((T8 * U) >> 30) / 9;
    localparam logic [63:0] T10 = ((T9 * U) >> 30) / 10;
    localparam logic [63:0] T11 = ((T10 * U) >> 30) / 11;
    localparam logic [63:0] T12 = ((T11 * U) >> 30) / 12;
    localparam logic signed [63:0] SUM = 64'sd1073741824
      - $signed(T1) + $signed(T2) - $signed(T3) + $signed(T4)
      - $signed(T5) + $signed(T6) - $signed(T7) + $signed(T8)
      - $signed(T9) + $signed(T10) - $signed(T11) + $signed(T12);
    localparam logic [40:0] TV = (SUM < 0) ? 41'd0 : 41'(SUM <<< 10);
    assign tab[i] = TV;
  end

  assign lo_tap = tab[seg];
  assign hi_tap = tab[seg + SW'(1)];

endmodule

// ===== design/gaussian_overlap_accumulator.sv =====
// Load, clear, read and unused opcodes, and out-of-range requests, go from the read state
// to the finish state; neighbour test and accumulate run the pair arithmetic in between.
// done and the result are registered in the finish state. No new item is taken until the
// last is through, and one shared multiplier steps through every product of the pair arithmetic.
// Reset: synchronous; a clearing pass over all NUM_COMPONENTS entries zeroes the sum memory
// while busy is high. Results are not back-pressured.
module gaussian_overlap_accumulator import gol_pkg::*; #(
  parameter int NUM_COMPONENTS = 256,
  parameter int NUM_TYPES      = 4,
  parameter int EXP_SEGMENTS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int CW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int NP = NUM_COMPONENTS * NUM_TYPES;
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int SW = $clog2(EXP_SEGMENTS + 1);
  localparam int GW = 16 + SW;
  localparam logic signed [55:0] TLIM = 56'sh100_0000_0000;

  typedef enum logic [17:0] {
    S_CLR  = 18'h00001,
    S_IDLE = 18'h00002,
    S_RD   = 18'h00004,
    S_PM   = 18'h00008,
    S_PA   = 18'h00010,
    S_QM   = 18'h00020,
    S_QA   = 18'h00040,
    S_YM   = 18'h00080,
    S_TL   = 18'h00100,
    S_IM   = 18'h00200,
    S_EX   = 18'h00400,
    S_OM1  = 18'h00800,
    S_OM2  = 18'h01000,
    S_OV   = 18'h02000,
    S_GM1  = 18'h04000,
    S_GM2  = 18'h08000,
    S_GA   = 18'h10000,
    S_FIN  = 18'h20000
  } state_t;

  state_t state;

  logic              accept, ok_in;
  logic [CW-1:0]     caddr_in, caddr, caddr_rd, clr_addr, sum_waddr;
  logic [PW-1:0]     paddr_in, paddr, paddr_rd;
  logic [2:0]        op;
  logic              ok;
  logic [31:0]       cutoff;
  logic signed [31:0] pos [3];
  logic signed [31:0] mean [3];
  logic signed [31:0] d [3];
  logic signed [31:0] p [3];
  logic [31:0]       cov [6];
  logic signed [31:0] thr_rd, pref_rd;
  logic [47:0]       sum_rd, sum_wdata;
  logic              sum_we;
  logic [1:0]        j, k;
  logic signed [49:0] pacc, qacc, pterm, psum, qsum;
  logic [31:0]       q;
  logic [15:0]       n, r;
  logic [SW-1:0]     s;
  logic [GW-1:0]     g;
  logic [31:0]       y;
  logic [40:0]       t0, t1, m, e;
  logic [30:0]       pf_pos;
  logic [53:0]       ovh;
  logic [57:0]       ovw;
  logic [47:0]       ov, ov_next;
  logic              inl;
  logic signed [55:0] th;
  logic signed [47:0] lo48;
  logic signed [57:0] gw;
  logic signed [47:0] grad [3];
  logic [48:0]       sum_add;
  logic [47:0]       sum_new;
  logic signed [36:0] ma;
  logic signed [32:0] mb;
  logic signed [69:0] prod;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign ok_in    = (32'(request.component) < NUM_COMPONENTS) &&
                    (32'(request.atom_type) < NUM_TYPES);
  assign caddr_in = CW'(request.component);
  assign paddr_in = PW'(PW'(request.atom_type) * PW'(NUM_COMPONENTS) + PW'(request.component));
  assign caddr_rd = (state == S_IDLE) ? caddr_in : caddr;
  assign paddr_rd = (state == S_IDLE) ? paddr_in : paddr;

  gol_ram #(.WIDTH(32), .DEPTH(NUM_COMPONENTS)) u_mean_x (
    .clk, .we(accept && ok_in && request.opcode == OP_LOAD && request.table_select == SEL_MEAN_X),
    .waddr(caddr_in), .wdata(request.load_value), .raddr(caddr_rd), .rdata(mean[0]));
  gol_ram #(.WIDTH(32), .DEPTH(NUM_COMPONENTS)) u_mean_y (
    .clk, .we(accept && ok_in && request.opcode == OP_LOAD && request.table_select == SEL_MEAN_Y),
    .waddr(caddr_in), .wdata(request.load_value), .raddr(caddr_rd), .rdata(mean[1]));
  gol_ram #(.WIDTH(32), .DEPTH(NUM_COMPONENTS)) u_mean_z (
    .clk, .we(accept && ok_in && request.opcode == OP_LOAD && request.table_select == SEL_MEAN_Z),
    .waddr(caddr_in), .wdata(request.load_value), .raddr(caddr_rd), .rdata(mean[2]));
  gol_ram #(.WIDTH(32), .DEPTH(NUM_COMPONENTS)) u_thresh (
    .clk, .we(accept && ok_in && request.opcode == OP_LOAD && request.table_select == SEL_THRESH),
    .waddr(caddr_in), .wdata(request.load_value), .raddr(caddr_rd), .rdata(thr_rd));
  gol_ram #(.WIDTH(32), .DEPTH(NP)) u_pref (
    .clk, .we(accept && ok_in && request.opcode == OP_LOAD && request.table_select == SEL_PREF),
    .waddr(paddr_in), .wdata(request.load_value), .raddr(paddr_rd), .rdata(pref_rd));

  for (genvar gi = 0; gi < 6; gi++) begin : g_cov
    gol_ram #(.WIDTH(32), .DEPTH(NP)) u_cov (
      .clk,
      .we(accept && ok_in && request.opcode == OP_LOAD &&
          request.table_select == 4'(SEL_COV_XX + gi)),
      .waddr(paddr_in), .wdata(request.load_value), .raddr(paddr_rd), .rdata(cov[gi]));
  end

  assign sum_waddr = (state == S_CLR) ? clr_addr : caddr;
  assign sum_we    = (state == S_CLR) ||
                     (state == S_FIN && ok && (op == OP_ACC || op == OP_CLEAR));
  assign sum_wdata = (state == S_FIN && op == OP_ACC) ? sum_new : '0;

  gol_ram #(.WIDTH(48), .DEPTH(NUM_COMPONENTS)) u_sum (
    .clk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata), .raddr(caddr_rd), .rdata(sum_rd));

  gol_exp_lut #(.SEGS(EXP_SEGMENTS)) u_exp (.seg(s), .lo_tap(t0), .hi_tap(t1));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_PM: begin
        ma = 37'(d[k]);
        mb = 33'($signed(cov[cov_index(j, k)]));
      end
      S_QM: begin
        ma = 37'(d[j]);
        mb = 33'(p[j]);
      end
      S_YM: begin
        ma = {5'b0, q};
        mb = {1'b0, LOG2E_Q30};
      end
      S_IM: begin
        ma = 37'($signed({1'b0, t0 - t1}));
        mb = {17'b0, r};
      end
      S_OM1: begin
        ma = {6'b0, pf_pos};
        mb = {12'b0, e[40:20]};
      end
      S_OM2: begin
        ma = {6'b0, pf_pos};
        mb = {13'b0, e[19:0]};
      end
      S_GM1: begin
        ma = {13'b0, ov[47:24]};
        mb = 33'(p[j]);
      end
      S_GM2: begin
        ma = {13'b0, ov[23:0]};
        mb = 33'(p[j]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign pterm  = 50'(prod >>> 16);
  assign psum   = pacc + pterm;
  assign qsum   = qacc + pterm;
  assign y      = prod[62:31];
  assign g      = GW'(y[15:0]) * GW'(EXP_SEGMENTS);
  assign m      = t0 - prod[56:16];
  assign pf_pos = pref_rd[31] ? 31'd0 : pref_rd[30:0];
  assign ovw    = {ovh, 4'b0} + 58'(prod[57:16]);

  always_comb begin
    ov_next = (ovw > 58'(MASK48)) ? MASK48 : ovw[47:0];
    if (op == OP_TEST && q > cutoff) begin
      ov_next = '0;
    end
  end

  assign lo48    = 48'(prod >>> 16);
  assign gw      = (58'(th) <<< 8) + 58'(lo48);
  assign sum_add = {1'b0, sum_rd} + {1'b0, ov};
  assign sum_new = sum_add[48] ? MASK48 : sum_add[47:0];

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      cutoff   <= '1;
      done     <= 1'b0;
      j        <= '0;
      k        <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cutoff <= cfg_data;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + CW'(1);
          if (clr_addr == CW'(NUM_COMPONENTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op     <= request.opcode;
            ok     <= ok_in;
            caddr  <= caddr_in;
            paddr  <= paddr_in;
            pos[0] <= request.pos_x;
            pos[1] <= request.pos_y;
            pos[2] <= request.pos_z;
            ov     <= '0;
            inl    <= 1'b0;
            for (int i = 0; i < 3; i++) grad[i] <= '0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          for (int i = 0; i < 3; i++) begin
            d[i] <= sat32(50'(33'(mean[i]) - 33'(pos[i])));
          end
          j    <= '0;
          k    <= '0;
          pacc <= '0;
          if (ok && (op == OP_TEST || op == OP_ACC)) state <= S_PM;
          else state <= S_FIN;
        end
        S_PM: state <= S_PA;
        S_PA: begin
          if (k == 2'd2) begin
            p[j] <= sat32(psum);
            pacc <= '0;
            k    <= '0;
            if (j == 2'd2) begin
              j     <= '0;
              qacc  <= '0;
              state <= S_QM;
            end else begin
              j     <= j + 2'd1;
              state <= S_PM;
            end
          end else begin
            pacc  <= psum;
            k     <= k + 2'd1;
            state <= S_PM;
          end
        end
        S_QM: state <= S_QA;
        S_QA: begin
          if (j == 2'd2) begin
            if (qsum < 0) q <= '0;
            else if (qsum > 50'sh0_FFFF_FFFF) q <= '1;
            else q <= qsum[31:0];
            j     <= '0;
            state <= S_YM;
          end else begin
            qacc  <= qsum;
            j     <= j + 2'd1;
            state <= S_QM;
          end
        end
        S_YM: state <= S_TL;
        S_TL: begin
          n     <= y[31:16];
          s     <= g[GW-1:16];
          r     <= g[15:0];
          state <= S_IM;
        end
        S_IM: state <= S_EX;
        S_EX: begin
          e     <= (n >= 16'd48) ? 41'd0 : (m >> n[5:0]);
          state <= S_OM1;
        end
        S_OM1: state <= S_OM2;
        S_OM2: begin
          ovh   <= prod[53:0];
          state <= S_OV;
        end
        S_OV: begin
          ov    <= ov_next;
          inl   <= $signed({9'b0, ov_next}) >= $signed({thr_rd[31], thr_rd, 24'b0});
          j     <= '0;
          state <= S_GM1;
        end
        S_GM1: state <= S_GM2;
        S_GM2: begin
          th    <= prod[55:0];
          state <= S_GA;
        end
        S_GA: begin
          if (th >= TLIM) grad[j] <= 48'sh7FFF_FFFF_FFFF;
          else if (th < -TLIM) grad[j] <= 48'sh8000_0000_0000;
          else grad[j] <= sat48(gw);
          if (j == 2'd2) begin
            j     <= '0;
            state <= S_FIN;
          end else begin
            j     <= j + 2'd1;
            state <= S_GM1;
          end
        end
        S_FIN: begin
          done                <= 1'b1;
          result.pair_overlap <= ov;
          result.grad_x       <= grad[0];
          result.grad_y       <= grad[1];
          result.grad_z       <= grad[2];
          result.in_list      <= inl;
          if (!ok) begin
            result.component_sum <= '0;
          end else begin
            case (op)
              OP_ACC:                     result.component_sum <= sum_new;
              OP_CLEAR:                   result.component_sum <= '0;
              OP_LOAD, OP_TEST, OP_READ:  result.component_sum <= sum_rd;
              default:                    result.component_sum <= sum_rd;
            endcase
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (!done && busy))
    else $error("activity during clearing pass");
`endif

endmodule
